// File: rtl/bmf_pkg.sv
`default_nettype none

package bmf_pkg;

  localparam int MAX_POINTS = 4;
  localparam int MAX_DEPTH  = 5;
  localparam int COORD_W    = 16;
  localparam int COEF_W     = 20;
  localparam int ACC_W      = 40;
  localparam int DEPTH_W    = 3;
  localparam int SHIFT_W    = 4;
  localparam int CNT_W      = $clog2((1 << MAX_DEPTH) + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  typedef struct packed {
    logic [2:0] point_count;
    coord_t     p0_x;
    coord_t     p0_y;
    coord_t     p1_x;
    coord_t     p1_y;
    coord_t     p2_x;
    coord_t     p2_y;
    coord_t     p3_x;
    coord_t     p3_y;
  } item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   last_vertex;
  } vertex_t;

  // power-basis coefficients of one axis, scaled so that a quadratic
  // runs through the same cubic stepper
  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t d;
  } coef_set_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    coord_t             c0_x;
    coord_t             c0_y;
    coef_t              a_x;
    coef_t              a_y;
    coef_t              b_x;
    coef_t              b_y;
    coef_t              d_x;
    coef_t              d_y;
    coord_t             end_x;
    coord_t             end_y;
  } job_t;

  function automatic coef_set_t axis_coefs(coord_t c0, coord_t c1, coord_t c2, coord_t c3,
                                           logic cubic);
    coef_t     e0, e1, e2, e3, d1, d2, d3;
    coef_set_t r;
    e0 = COEF_W'(c0);
    e1 = COEF_W'(c1);
    e2 = COEF_W'(c2);
    e3 = COEF_W'(c3);
    d1 = e1 - e0;
    d2 = e0 - (e1 <<< 1) + e2;
    d3 = e3 - (e2 <<< 1) - e2 + (e1 <<< 1) + e1 - e0;
    if (cubic) begin
      r.a = (d1 <<< 1) + d1;
      r.b = (d2 <<< 1) + d2;
      r.d = d3;
    end else begin
      r.a = d1 <<< 1;
      r.b = d2;
      r.d = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bezier_midpoint_flattening_unit.sv
// Bezier flattening unit: takes one curve of 2 to 4 control points (signed
// Q12.4) on the item channel and returns its polyline on the vtx channel.
// Both channels use valid/ready; a transfer happens when both are high.
// The cfg port writes the subdivision depth (0..5, reset 4) with cfg_we;
// write it only while no curve is in flight.
// A curve of 3 or 4 points yields 2^depth + 1 vertices, a 2-point curve
// yields its two points; the final vertex carries last_vertex.
// Throughput: one vertex per cycle while vtx_ready is high and curves are
// queued, set by the single forward-difference stepper in the back end. The
// next curve loads while the end point goes out. When the back end is idle,
// a curve passes through the queue, then the stepper registers, then the
// output register before its first vertex is valid.
// A small job queue sits between the front end and the back end, so the
// item channel keeps taking curves while vertices drain.
// When vtx_ready is low the output register holds its vertex and the
// stepper waits; curves keep entering until the queue is full.
// Synchronous reset empties the queue, drops any curve in progress and
// sets the depth back to 4.
`default_nettype none

module bezier_midpoint_flattening_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bmf_pkg::DEPTH_W-1:0]  cfg_data,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  bmf_pkg::item_t               item,
  output logic                         vtx_valid,
  input  logic                         vtx_ready,
  output bmf_pkg::vertex_t             vtx
);

  logic [bmf_pkg::DEPTH_W-1:0] depth;
  logic                        push;
  logic                        full;
  logic                        pop;
  logic                        q_valid;
  bmf_pkg::job_t               wr_job;
  bmf_pkg::job_t               rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= bmf_pkg::DEPTH_W'(4);
    end else if (cfg_we) begin
      depth <= cfg_data;
    end
  end

  bmf_front u_front (
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .depth      (depth),
    .full       (full),
    .push       (push),
    .job        (wr_job)
  );

  bmf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (wr_job),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_job   (rd_job)
  );

  bmf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (rd_job),
    .pop       (pop),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx)
  );

endmodule

`default_nettype wire

// File: rtl/bmf_front.sv
`default_nettype none

module bmf_front (
  input  bmf_pkg::item_t                  item,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic [bmf_pkg::DEPTH_W-1:0]     depth,
  input  logic                            full,
  output logic                            push,
  output bmf_pkg::job_t                   job
);

  logic [2:0]                      n;
  logic                            cubic;
  logic [bmf_pkg::DEPTH_W-1:0]     dep;
  bmf_pkg::coef_set_t              cx;
  bmf_pkg::coef_set_t              cy;

  assign item_ready = !full;
  assign push       = item_valid && !full;

  always_comb begin
    n = item.point_count;
    if (n < 3'd2) begin
      n = 3'd2;
    end
    if (n > 3'(bmf_pkg::MAX_POINTS)) begin
      n = 3'(bmf_pkg::MAX_POINTS);
    end
    cubic = (n == 3'd4);

    // a line is emitted as its two end points: no subdivision
    if (n == 3'd2) begin
      dep = '0;
    end else if (depth > bmf_pkg::DEPTH_W'(bmf_pkg::MAX_DEPTH)) begin
      dep = bmf_pkg::DEPTH_W'(bmf_pkg::MAX_DEPTH);
    end else begin
      dep = depth;
    end

    cx = bmf_pkg::axis_coefs(item.p0_x, item.p1_x, item.p2_x, item.p3_x, cubic);
    cy = bmf_pkg::axis_coefs(item.p0_y, item.p1_y, item.p2_y, item.p3_y, cubic);

    job.depth = dep;
    job.c0_x  = item.p0_x;
    job.c0_y  = item.p0_y;
    job.a_x   = cx.a;
    job.a_y   = cy.a;
    job.b_x   = cx.b;
    job.b_y   = cy.b;
    job.d_x   = cx.d;
    job.d_y   = cy.d;
    case (n)
      3'd2: begin
        job.end_x = item.p1_x;
        job.end_y = item.p1_y;
      end
      3'd3: begin
        job.end_x = item.p2_x;
        job.end_y = item.p2_y;
      end
      default: begin
        job.end_x = item.p3_x;
        job.end_y = item.p3_y;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bmf_queue.sv
`default_nettype none

module bmf_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bmf_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output bmf_pkg::job_t rd_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bmf_pkg::job_t  mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bmf_back.sv
`default_nettype none

module bmf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  bmf_pkg::job_t    job,
  output logic             pop,
  output logic             vtx_valid,
  input  logic             vtx_ready,
  output bmf_pkg::vertex_t vtx
);

  typedef struct packed {
    bmf_pkg::acc_t f;
    bmf_pkg::acc_t d1;
    bmf_pkg::acc_t d2;
    bmf_pkg::acc_t d3;
  } fwd_t;

  // forward differences of the curve scaled by 8^depth, step t = 1/2^depth
  function automatic fwd_t fwd_init(bmf_pkg::coord_t c0, bmf_pkg::coef_t a,
                                    bmf_pkg::coef_t b, bmf_pkg::coef_t d,
                                    logic [bmf_pkg::DEPTH_W-1:0] dep);
    bmf_pkg::acc_t                ec, ea, eb, ed;
    logic [bmf_pkg::SHIFT_W-1:0]  s3;
    fwd_t                         r;
    ec   = bmf_pkg::ACC_W'(c0);
    ea   = bmf_pkg::ACC_W'(a);
    eb   = bmf_pkg::ACC_W'(b);
    ed   = bmf_pkg::ACC_W'(d);
    s3   = bmf_pkg::SHIFT_W'(dep) + {dep, 1'b0};
    r.f  = ec <<< s3;
    r.d3 = (ed <<< 2) + (ed <<< 1);
    r.d1 = (ea <<< {dep, 1'b0}) + (eb <<< dep) + ed;
    r.d2 = ((eb <<< 1) <<< dep) + r.d3;
    return r;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic bmf_pkg::coord_t round_q(bmf_pkg::acc_t v,
                                              logic [bmf_pkg::SHIFT_W-1:0] s);
    bmf_pkg::acc_t half;
    bmf_pkg::acc_t t;
    half = bmf_pkg::acc_t'((bmf_pkg::ACC_W'(1) << s) >> 1);
    t    = v + half;
    t    = t >>> s;
    return t[bmf_pkg::COORD_W-1:0];
  endfunction

  logic                            busy;
  fwd_t                            fx;
  fwd_t                            fy;
  fwd_t                            ix;
  fwd_t                            iy;
  logic [bmf_pkg::CNT_W-1:0]       left;
  logic [bmf_pkg::SHIFT_W-1:0]     sh;
  bmf_pkg::coord_t                 end_x;
  bmf_pkg::coord_t                 end_y;
  logic                            emit;
  logic                            at_end;

  assign at_end = (left == '0);
  assign emit   = busy && (!vtx_valid || vtx_ready);
  // the next curve loads in the same cycle as the end point goes out
  assign pop    = job_valid && (!busy || (emit && at_end));

  always_comb begin
    ix = fwd_init(job.c0_x, job.a_x, job.b_x, job.d_x, job.depth);
    iy = fwd_init(job.c0_y, job.a_y, job.b_y, job.d_y, job.depth);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      vtx_valid <= 1'b0;
    end else begin
      if (emit) begin
        vtx_valid <= 1'b1;
      end else if (vtx_ready) begin
        vtx_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && at_end) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (at_end) begin
        vtx.out_x       <= end_x;
        vtx.out_y       <= end_y;
        vtx.last_vertex <= 1'b1;
      end else begin
        vtx.out_x       <= round_q(fx.f, sh);
        vtx.out_y       <= round_q(fy.f, sh);
        vtx.last_vertex <= 1'b0;
      end
    end
    if (pop) begin
      fx    <= ix;
      fy    <= iy;
      left  <= bmf_pkg::CNT_W'(1) << job.depth;
      sh    <= bmf_pkg::SHIFT_W'(job.depth) + {job.depth, 1'b0};
      end_x <= job.end_x;
      end_y <= job.end_y;
    end else if (emit && !at_end) begin
      fx.f  <= fx.f + fx.d1;
      fx.d1 <= fx.d1 + fx.d2;
      fx.d2 <= fx.d2 + fx.d3;
      fy.f  <= fy.f + fy.d1;
      fy.d1 <= fy.d1 + fy.d2;
      fy.d2 <= fy.d2 + fy.d3;
      left  <= left - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bmf_checker.sv
`default_nettype none

module bmf_checker (
  input logic             clk,
  input logic             rst,
  input logic             vtx_valid,
  input logic             vtx_ready,
  input bmf_pkg::vertex_t vtx
);

  // stalled vertex holds
  a_vtx_hold: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && !vtx_ready |=> vtx_valid && $stable(vtx))
    else $error("vertex changed or dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !vtx_valid)
    else $error("vertex valid right after reset");

  // vertices of one curve come back to back while the receiver takes them
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && vtx_ready && !vtx.last_vertex |=> vtx_valid)
    else $error("gap inside a polyline");

  a_drop_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(vtx_valid) && !$past(rst) |-> $past(vtx.last_vertex))
    else $error("output went idle before the last vertex");

endmodule

bind bezier_midpoint_flattening_unit bmf_checker u_bmf_checker (
  .clk       (clk),
  .rst       (rst),
  .vtx_valid (vtx_valid),
  .vtx_ready (vtx_ready),
  .vtx       (vtx)
);

`default_nettype wire
